// ===== src/pmdg_pkg.sv =====
// ----------------------------------------------------------------------------
// pmdg_pkg: shared types and constants for the point-mass derivative block
// Request and result structs, register indexes, reset values and the
// stage counts that set the pipeline's fixed latency.
// ----------------------------------------------------------------------------
package pmdg_pkg;

	// Iterative units, one step per pipeline stage.
	localparam int SQRT_STAGES  = 32;
	localparam int DIV_STEPS    = 75;
	localparam int ACC_STEPS    = 32;

	// Front stages up to the lane numerators, then alignment to the square root.
	localparam int FRONT_STAGES = 9;
	localparam int ALIGN_DEPTH  = 3 + SQRT_STAGES - FRONT_STAGES;
	localparam int POST_DEPTH   = ACC_STEPS + 1;
	localparam int LATENCY      = FRONT_STAGES + ALIGN_DEPTH + DIV_STEPS + 1 + POST_DEPTH + 1;

	// Configuration register indexes and reset values.
	localparam logic [1:0]  REG_GRAVITY   = 2'd0;
	localparam logic [1:0]  REG_DENSITY   = 2'd1;
	localparam logic [31:0] GRAVITY_RESET = 32'd642690;
	localparam logic [31:0] DENSITY_RESET = 32'd20552090;

	typedef struct packed {
		logic signed [31:0] vel_x;
		logic signed [31:0] vel_y;
		logic signed [31:0] vel_z;
		logic [31:0]        air_density;
		logic [31:0]        mass;
		logic [15:0]        drag_coef;
		logic [31:0]        ref_area;
	} req_t;

	typedef struct packed {
		logic signed [31:0] accel_x;
		logic signed [31:0] accel_y;
		logic signed [31:0] accel_z;
		logic signed [47:0] force_x;
		logic signed [47:0] force_y;
		logic signed [47:0] force_z;
		logic [47:0]        dyn_pressure;
		logic               mass_fault;
	} rsp_t;

	// Per-request values that ride alongside the arithmetic.
	typedef struct packed {
		logic [2:0]  vneg;
		logic [31:0] mass;
		logic [47:0] grav;
		logic        area_nz;
		logic        fault;
		logic [47:0] dynp;
	} side_t;

	// Total force per axis after gravity is merged in.
	typedef struct packed {
		logic [2:0]       fneg;
		logic [2:0][75:0] fmag;
		logic [31:0]      mass;
		logic             fault;
		logic [47:0]      dynp;
	} post_t;

endpackage

// ===== src/pmdg_isqrt.sv =====
// ----------------------------------------------------------------------------
// pmdg_isqrt: pipelined integer square root
// Floor square root of a 64-bit value, one result bit per stage.
// ----------------------------------------------------------------------------
module pmdg_isqrt (
	input  logic        clk,
	input  logic [63:0] din,
	output logic [31:0] root
);

	logic [63:0] v_q [pmdg_pkg::SQRT_STAGES];
	logic [63:0] r_q [pmdg_pkg::SQRT_STAGES];
	logic [63:0] v_d [pmdg_pkg::SQRT_STAGES];
	logic [63:0] r_d [pmdg_pkg::SQRT_STAGES];

	// Each stage tries one bit pair of the remainder.
	always_comb begin
		logic [63:0] vi, ri, bitc, t;
		for (int k = 0; k < pmdg_pkg::SQRT_STAGES; k++) begin
			vi   = (k == 0) ? din : v_q[(k == 0) ? 0 : k - 1];
			ri   = (k == 0) ? 64'd0 : r_q[(k == 0) ? 0 : k - 1];
			bitc = 64'd1 << (62 - 2 * k);
			t    = ri + bitc;
			if (vi >= t) begin
				v_d[k] = vi - t;
				r_d[k] = (ri >> 1) + bitc;
			end else begin
				v_d[k] = vi;
				r_d[k] = ri >> 1;
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::SQRT_STAGES; k++) begin
			v_q[k] <= v_d[k];
			r_q[k] <= r_d[k];
		end
	end

	assign root = r_q[pmdg_pkg::SQRT_STAGES - 1][31:0];

endmodule

// ===== src/pmdg_drag_lane.sv =====
// ----------------------------------------------------------------------------
// pmdg_drag_lane: one axis of the drag split
// Divides drag magnitude times the axis speed by the total speed with a
// pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module pmdg_drag_lane (
	input  logic         clk,
	input  logic [106:0] num,
	input  logic [31:0]  speed,
	input  logic         en,
	output logic [74:0]  fmag
);

	logic [31:0] rem_q [pmdg_pkg::DIV_STEPS];
	logic [74:0] low_q [pmdg_pkg::DIV_STEPS];
	logic [74:0] quo_q [pmdg_pkg::DIV_STEPS];
	logic [31:0] spd_q [pmdg_pkg::DIV_STEPS];
	logic        en_q  [pmdg_pkg::DIV_STEPS];
	logic [31:0] rem_d [pmdg_pkg::DIV_STEPS];
	logic [74:0] low_d [pmdg_pkg::DIV_STEPS];
	logic [74:0] quo_d [pmdg_pkg::DIV_STEPS];
	logic [31:0] spd_d [pmdg_pkg::DIV_STEPS];
	logic        en_d  [pmdg_pkg::DIV_STEPS];

	// The quotient is known to fit in 75 bits, so the top bits seed the remainder.
	always_comb begin
		logic [31:0] remi, spdi;
		logic [74:0] lowi, quoi;
		logic        eni, ge;
		logic [32:0] r2;
		for (int k = 0; k < pmdg_pkg::DIV_STEPS; k++) begin
			if (k == 0) begin
				remi = num[106:75];
				lowi = num[74:0];
				quoi = 75'd0;
				spdi = speed;
				eni  = en;
			end else begin
				remi = rem_q[(k == 0) ? 0 : k - 1];
				lowi = low_q[(k == 0) ? 0 : k - 1];
				quoi = quo_q[(k == 0) ? 0 : k - 1];
				spdi = spd_q[(k == 0) ? 0 : k - 1];
				eni  = en_q[(k == 0) ? 0 : k - 1];
			end
			r2       = {remi, lowi[74]};
			ge       = (r2 >= {1'b0, spdi});
			rem_d[k] = ge ? 32'(r2 - {1'b0, spdi}) : r2[31:0];
			low_d[k] = {lowi[73:0], 1'b0};
			quo_d[k] = {quoi[73:0], ge};
			spd_d[k] = spdi;
			en_d[k]  = eni;
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::DIV_STEPS; k++) begin
			rem_q[k] <= rem_d[k];
			low_q[k] <= low_d[k];
			quo_q[k] <= quo_d[k];
			spd_q[k] <= spd_d[k];
			en_q[k]  <= en_d[k];
		end
	end

	assign fmag = en_q[pmdg_pkg::DIV_STEPS - 1] ? quo_q[pmdg_pkg::DIV_STEPS - 1] : 75'd0;

endmodule

// ===== src/pmdg_accel_lane.sv =====
// ----------------------------------------------------------------------------
// pmdg_accel_lane: one axis of force divided by mass
// Flags quotients of 32 bits or more up front, then finds the low 32
// quotient bits with a pipelined restoring divider.
// ----------------------------------------------------------------------------
module pmdg_accel_lane (
	input  logic        clk,
	input  logic [75:0] fmag,
	input  logic [31:0] mass,
	output logic [31:0] quo,
	output logic        ovf
);

	logic [31:0] rem_s1, low_s1, mass_s1;
	logic        ovf_s1;
	logic [31:0] rem_q  [pmdg_pkg::ACC_STEPS];
	logic [31:0] low_q  [pmdg_pkg::ACC_STEPS];
	logic [31:0] quo_q  [pmdg_pkg::ACC_STEPS];
	logic [31:0] mass_q [pmdg_pkg::ACC_STEPS];
	logic        ovf_q  [pmdg_pkg::ACC_STEPS];
	logic [31:0] rem_d  [pmdg_pkg::ACC_STEPS];
	logic [31:0] low_d  [pmdg_pkg::ACC_STEPS];
	logic [31:0] quo_d  [pmdg_pkg::ACC_STEPS];

	// Setup stage: the numerator is force shifted up by 16 bits.
	always_ff @(posedge clk) begin
		ovf_s1  <= (fmag[75:16] >= {28'd0, mass});
		rem_s1  <= fmag[47:16];
		low_s1  <= {fmag[15:0], 16'd0};
		mass_s1 <= mass;
	end

	// One quotient bit per stage.
	always_comb begin
		logic [31:0] remi, lowi, quoi, mi;
		logic [32:0] r2;
		logic        ge;
		for (int k = 0; k < pmdg_pkg::ACC_STEPS; k++) begin
			remi     = (k == 0) ? rem_s1 : rem_q[(k == 0) ? 0 : k - 1];
			lowi     = (k == 0) ? low_s1 : low_q[(k == 0) ? 0 : k - 1];
			quoi     = (k == 0) ? 32'd0 : quo_q[(k == 0) ? 0 : k - 1];
			mi       = (k == 0) ? mass_s1 : mass_q[(k == 0) ? 0 : k - 1];
			r2       = {remi, lowi[31]};
			ge       = (r2 >= {1'b0, mi});
			rem_d[k] = ge ? 32'(r2 - {1'b0, mi}) : r2[31:0];
			low_d[k] = {lowi[30:0], 1'b0};
			quo_d[k] = {quoi[30:0], ge};
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::ACC_STEPS; k++) begin
			rem_q[k]  <= rem_d[k];
			low_q[k]  <= low_d[k];
			quo_q[k]  <= quo_d[k];
			mass_q[k] <= (k == 0) ? mass_s1 : mass_q[(k == 0) ? 0 : k - 1];
			ovf_q[k]  <= (k == 0) ? ovf_s1 : ovf_q[(k == 0) ? 0 : k - 1];
		end
	end

	assign quo = quo_q[pmdg_pkg::ACC_STEPS - 1];
	assign ovf = ovf_q[pmdg_pkg::ACC_STEPS - 1];

endmodule

// ===== src/point_mass_drag_gravity_derivative.sv =====
// ----------------------------------------------------------------------------
// point_mass_drag_gravity_derivative: drag and gravity force on a point mass
// Fixed-point speed, dynamic pressure, drag, gravity, force and acceleration.
// ----------------------------------------------------------------------------
// A request is taken on every clock cycle (busy stays low) and its result
// appears on the result port, marked by done for one cycle, in request order.
// The latency is set by three chains of one-bit-per-stage units in series:
// the 32-stage square root, the 75-stage divider of the three drag lanes and
// the 33-stage force-by-mass divider of the three acceleration lanes. The
// receiver cannot stall the output, so results must be captured in the cycle
// done is high. Configuration writes are always ready and are to be made
// while no request is in flight.
// ----------------------------------------------------------------------------
module point_mass_drag_gravity_derivative (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pmdg_pkg::req_t   req,
	input  logic             cfg_valid,
	output logic             cfg_ready,
	input  logic [1:0]       cfg_index,
	input  logic [31:0]      cfg_data,
	output pmdg_pkg::rsp_t   result,
	output logic             done
);

	logic [31:0] grav_q, dens_q;
	logic [pmdg_pkg::LATENCY-1:0] vld_q;

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grav_q <= pmdg_pkg::GRAVITY_RESET;
			dens_q <= pmdg_pkg::DENSITY_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				pmdg_pkg::REG_GRAVITY: grav_q <= cfg_data;
				pmdg_pkg::REG_DENSITY: dens_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Valid bit for every pipeline stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[pmdg_pkg::LATENCY-2:0], start & ~busy};
		end
	end

	assign done = vld_q[pmdg_pkg::LATENCY-1];

	// Stage 1: velocity magnitudes and density selection.
	logic [2:0][31:0] raw;
	logic [2:0][31:0] vmag_s1, vmag_s2, vmag_s3, vmag_s4, vmag_s5, vmag_s6, vmag_s7;
	logic [2:0]       vneg_s1, vneg_s2, vneg_s3;
	logic [31:0]      rho_s1, rho_s2, rho_s3, mass_s1, mass_s2, mass_s3, area_s1;
	logic [15:0]      cx_s1;
	logic             fault_s1, fault_s2, fault_s3, anz_s2, anz_s3;

	assign raw[0] = req.vel_x;
	assign raw[1] = req.vel_y;
	assign raw[2] = req.vel_z;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			vneg_s1[i] <= raw[i][31];
			vmag_s1[i] <= raw[i][31] ? 32'd0 - raw[i] : raw[i];
		end
		rho_s1   <= (req.air_density == 32'd0) ? dens_q : req.air_density;
		mass_s1  <= req.mass;
		cx_s1    <= req.drag_coef;
		area_s1  <= req.ref_area;
		fault_s1 <= (req.mass == 32'd0);
	end

	// Stage 2: squares, coefficient times area, mass times gravity.
	logic [2:0][63:0] sq_s2;
	logic [47:0]      cxa_s2, cxa_s3, cxa_s4, cxa_s5;
	logic [63:0]      gp_s2;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= vmag_s1[i] * vmag_s1[i];
		end
		cxa_s2   <= cx_s1 * area_s1;
		gp_s2    <= mass_s1 * grav_q;
		vmag_s2  <= vmag_s1;
		vneg_s2  <= vneg_s1;
		rho_s2   <= rho_s1;
		mass_s2  <= mass_s1;
		anz_s2   <= (area_s1 != 32'd0);
		fault_s2 <= fault_s1;
	end

	// Stage 3: speed squared and gravity force.
	logic [63:0] v2_s3;
	logic [47:0] grav_s3;

	always_ff @(posedge clk) begin
		v2_s3    <= sq_s2[0] + sq_s2[1] + sq_s2[2];
		grav_s3  <= gp_s2[63:16];
		cxa_s3   <= cxa_s2;
		vmag_s3  <= vmag_s2;
		vneg_s3  <= vneg_s2;
		rho_s3   <= rho_s2;
		mass_s3  <= mass_s2;
		anz_s3   <= anz_s2;
		fault_s3 <= fault_s2;
	end

	pmdg_pkg::side_t side_s3, side_s4, side_s5, side_s6, side_s7, side_s8, side_s9;

	always_comb begin
		side_s3         = '0;
		side_s3.vneg    = vneg_s3;
		side_s3.mass    = mass_s3;
		side_s3.grav    = grav_s3;
		side_s3.area_nz = anz_s3;
		side_s3.fault   = fault_s3;
	end

	// Speed runs in parallel with the pressure and drag chain.
	logic [31:0] speed;

	pmdg_isqrt u_isqrt (
		.clk  (clk),
		.din  (v2_s3),
		.root (speed)
	);

	// Stage 4: density times speed squared, as two partial products.
	logic [63:0] prl_s4, prh_s4;

	always_ff @(posedge clk) begin
		prl_s4  <= rho_s3 * v2_s3[31:0];
		prh_s4  <= rho_s3 * v2_s3[63:32];
		cxa_s4  <= cxa_s3;
		vmag_s4 <= vmag_s3;
		side_s4 <= side_s3;
	end

	// Stage 5: dynamic pressure.
	logic [95:0]     rv2;
	logic [54:0]     qf;
	logic [54:0]     qf_s5;
	pmdg_pkg::side_t side_d5;

	assign rv2 = {32'd0, prl_s4} + {prh_s4, 32'd0};
	assign qf  = rv2[95:41];

	always_comb begin
		side_d5      = side_s4;
		side_d5.dynp = (|qf[54:48]) ? 48'hFFFF_FFFF_FFFF : qf[47:0];
	end

	always_ff @(posedge clk) begin
		qf_s5   <= qf;
		cxa_s5  <= cxa_s4;
		vmag_s5 <= vmag_s4;
		side_s5 <= side_d5;
	end

	// Stage 6: drag magnitude partial products.
	logic [63:0] p00_s6;
	logic [54:0] p01_s6;
	logic [47:0] p10_s6;
	logic [38:0] p11_s6;

	always_ff @(posedge clk) begin
		p00_s6  <= cxa_s5[31:0] * qf_s5[31:0];
		p01_s6  <= cxa_s5[31:0] * qf_s5[54:32];
		p10_s6  <= cxa_s5[47:32] * qf_s5[31:0];
		p11_s6  <= cxa_s5[47:32] * qf_s5[54:32];
		vmag_s6 <= vmag_s5;
		side_s6 <= side_s5;
	end

	// Stage 7: drag magnitude.
	logic [102:0] dsum;
	logic [74:0]  dmag_s7;

	assign dsum = {39'd0, p00_s6} + {16'd0, p01_s6, 32'd0} + {23'd0, p10_s6, 32'd0}
		+ {p11_s6, 64'd0};

	always_ff @(posedge clk) begin
		dmag_s7 <= dsum[102:28];
		vmag_s7 <= vmag_s6;
		side_s7 <= side_s6;
	end

	// Stage 8: drag times axis speed, three slices per lane.
	logic [2:0][2:0][56:0] np_s8;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			np_s8[i][0] <= dmag_s7[24:0] * vmag_s7[i];
			np_s8[i][1] <= dmag_s7[49:25] * vmag_s7[i];
			np_s8[i][2] <= dmag_s7[74:50] * vmag_s7[i];
		end
		side_s8 <= side_s7;
	end

	// Stage 9: lane numerators.
	logic [2:0][106:0] num_s9;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			num_s9[i] <= {50'd0, np_s8[i][0]} + {25'd0, np_s8[i][1], 25'd0}
				+ {np_s8[i][2], 50'd0};
		end
		side_s9 <= side_s8;
	end

	// Hold numerators until the speed leaves the square root.
	logic [2:0][106:0] num_al_q  [pmdg_pkg::ALIGN_DEPTH];
	pmdg_pkg::side_t   side_al_q [pmdg_pkg::ALIGN_DEPTH];

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::ALIGN_DEPTH; k++) begin
			num_al_q[k]  <= (k == 0) ? num_s9 : num_al_q[(k == 0) ? 0 : k - 1];
			side_al_q[k] <= (k == 0) ? side_s9 : side_al_q[(k == 0) ? 0 : k - 1];
		end
	end

	// Drag lanes, one per axis.
	logic             drag_en;
	logic [2:0][74:0] lane_f;

	assign drag_en = (speed != 32'd0) && side_al_q[pmdg_pkg::ALIGN_DEPTH-1].area_nz;

	for (genvar i = 0; i < 3; i++) begin : g_drag
		pmdg_drag_lane u_lane (
			.clk   (clk),
			.num   (num_al_q[pmdg_pkg::ALIGN_DEPTH-1][i]),
			.speed (speed),
			.en    (drag_en),
			.fmag  (lane_f[i])
		);
	end

	pmdg_pkg::side_t side_dv_q [pmdg_pkg::DIV_STEPS];

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::DIV_STEPS; k++) begin
			side_dv_q[k] <= (k == 0) ? side_al_q[pmdg_pkg::ALIGN_DEPTH-1]
				: side_dv_q[(k == 0) ? 0 : k - 1];
		end
	end

	// Merge stage: drag opposes velocity, gravity joins the vertical axis.
	pmdg_pkg::side_t side_m;
	pmdg_pkg::post_t mrg_d, mrg_s111;
	logic [75:0]     dz, gz;

	assign side_m = side_dv_q[pmdg_pkg::DIV_STEPS-1];
	assign dz     = {1'b0, lane_f[2]};
	assign gz     = {28'd0, side_m.grav};

	always_comb begin
		mrg_d         = '0;
		mrg_d.mass    = side_m.mass;
		mrg_d.fault   = side_m.fault;
		mrg_d.dynp    = side_m.dynp;
		mrg_d.fneg    = ~side_m.vneg;
		mrg_d.fmag[0] = {1'b0, lane_f[0]};
		mrg_d.fmag[1] = {1'b0, lane_f[1]};
		if (!side_m.vneg[2]) begin
			mrg_d.fmag[2] = dz + gz;
		end else if (dz >= gz) begin
			mrg_d.fmag[2] = dz - gz;
		end else begin
			mrg_d.fneg[2] = 1'b1;
			mrg_d.fmag[2] = gz - dz;
		end
	end

	always_ff @(posedge clk) begin
		mrg_s111 <= mrg_d;
	end

	// Acceleration lanes.
	logic [2:0][31:0] quo;
	logic [2:0]       ovf;

	for (genvar i = 0; i < 3; i++) begin : g_accel
		pmdg_accel_lane u_lane (
			.clk  (clk),
			.fmag (mrg_s111.fmag[i]),
			.mass (mrg_s111.mass),
			.quo  (quo[i]),
			.ovf  (ovf[i])
		);
	end

	pmdg_pkg::post_t post_q [pmdg_pkg::POST_DEPTH];

	always_ff @(posedge clk) begin
		for (int k = 0; k < pmdg_pkg::POST_DEPTH; k++) begin
			post_q[k] <= (k == 0) ? mrg_s111 : post_q[(k == 0) ? 0 : k - 1];
		end
	end

	// Output stage: saturate, apply sign, on a mass fault zero all but the fault flag.
	pmdg_pkg::post_t  pf;
	logic [2:0][31:0] acc;
	logic [2:0][47:0] frc;
	pmdg_pkg::rsp_t   res_d, res_q;

	assign pf = post_q[pmdg_pkg::POST_DEPTH-1];

	always_comb begin
		logic [75:0] lim48;
		logic [47:0] m48;
		logic [31:0] lim32, m32;
		for (int i = 0; i < 3; i++) begin
			lim48  = pf.fneg[i] ? 76'h800000000000 : 76'h7FFFFFFFFFFF;
			m48    = (pf.fmag[i] > lim48) ? lim48[47:0] : pf.fmag[i][47:0];
			frc[i] = pf.fneg[i] ? 48'd0 - m48 : m48;
			lim32  = pf.fneg[i] ? 32'h8000_0000 : 32'h7FFF_FFFF;
			m32    = (ovf[i] || quo[i] > lim32) ? lim32 : quo[i];
			acc[i] = pf.fneg[i] ? 32'd0 - m32 : m32;
		end
		res_d = '0;
		if (pf.fault) begin
			res_d.mass_fault = 1'b1;
		end else begin
			res_d.accel_x      = $signed(acc[0]);
			res_d.accel_y      = $signed(acc[1]);
			res_d.accel_z      = $signed(acc[2]);
			res_d.force_x      = $signed(frc[0]);
			res_d.force_y      = $signed(frc[1]);
			res_d.force_z      = $signed(frc[2]);
			res_d.dyn_pressure = pf.dynp;
		end
	end

	always_ff @(posedge clk) begin
		res_q <= res_d;
	end

	assign result = res_q;

endmodule

// ===== dv/point_mass_drag_gravity_derivative_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// point_mass_drag_gravity_derivative_tb: self-checking bench for the block
// Drives requests with random idle gaps through several register settings.
// Every result is checked field by field against an in-bench fixed-point
// model of speed, dynamic pressure, drag, gravity, force and acceleration.
// ----------------------------------------------------------------------------
module point_mass_drag_gravity_derivative_tb;

	localparam int CYCLE_LIMIT = 400000;

	// Scoreboard: predicts each accepted request and checks results in order.
	class drag_scoreboard;
		logic [31:0]     gravity;
		logic [31:0]     density;
		pmdg_pkg::rsp_t  pending[$];
		int              errors;
		int              checked;
		int              faults;

		function new();
			gravity = pmdg_pkg::GRAVITY_RESET;
			density = pmdg_pkg::DENSITY_RESET;
			errors  = 0;
			checked = 0;
			faults  = 0;
		endfunction

		// Integer square root by bit-pair restoring method.
		function logic [63:0] int_sqrt(logic [63:0] v);
			logic [63:0] root;
			logic [63:0] rem;
			logic [63:0] trial;
			root = 0;
			rem  = v;
			for (int b = 31; b >= 0; b--) begin
				trial = (root << (b + 1)) + (64'd1 << (2 * b));
				if (rem >= trial) begin
					rem  = rem - trial;
					root = root | (64'd1 << b);
				end
			end
			return root;
		endfunction

		// Clamp a sign and magnitude pair to a signed field of the given width.
		function logic [63:0] clamp_signed(logic neg, logic [127:0] mag, int width);
			logic [127:0] lim;
			logic [63:0]  m;
			lim = (128'd1 << (width - 1)) - (neg ? 128'd0 : 128'd1);
			m = (mag > lim) ? lim[63:0] : mag[63:0];
			m = neg ? (64'd0 - m) : m;
			return m & ((64'd1 << width) - 1);
		endfunction

		function pmdg_pkg::rsp_t predict(pmdg_pkg::req_t r);
			pmdg_pkg::rsp_t p;
			logic [31:0]  vmag[3];
			logic         vneg[3];
			logic         fneg[3];
			logic [127:0] fmag[3];
			logic [63:0]  v2;
			logic [63:0]  speed;
			logic [31:0]  rho;
			logic [127:0] qf;
			logic [127:0] dmag;
			logic [127:0] grav;
			logic [31:0]  raw;
			p = '0;
			if (r.mass == 0) begin
				p.mass_fault = 1'b1;
				return p;
			end
			v2 = 0;
			for (int i = 0; i < 3; i++) begin
				raw = (i == 0) ? r.vel_x : (i == 1) ? r.vel_y : r.vel_z;
				vneg[i] = raw[31];
				vmag[i] = raw[31] ? (32'd0 - raw) : raw;
				if (raw == 32'h8000_0000)
					v2 = v2 + (64'd1 << 62);
				else
					v2 = v2 + 64'(vmag[i]) * 64'(vmag[i]);
			end
			rho   = (r.air_density == 0) ? density : r.air_density;
			speed = int_sqrt(v2);
			qf    = (128'(rho) * 128'(v2)) >> 41;
			p.dyn_pressure = (qf > 128'hFFFF_FFFF_FFFF) ? 48'hFFFF_FFFF_FFFF : qf[47:0];
			dmag = (128'(r.drag_coef) * 128'(r.ref_area) * qf) >> 28;
			for (int i = 0; i < 3; i++) begin
				fneg[i] = !vneg[i];
				fmag[i] = 0;
				if (speed != 0 && r.ref_area != 0) begin
					// Minimum negative velocity has magnitude 2^31.
					if (vneg[i] && vmag[i] == 32'h8000_0000)
						fmag[i] = (dmag * (128'd1 << 31)) / 128'(speed);
					else
						fmag[i] = (dmag * 128'(vmag[i])) / 128'(speed);
				end
			end
			// Merge gravity into the vertical axis.
			grav = (128'(r.mass) * 128'(gravity)) >> 16;
			if (fneg[2])
				fmag[2] = fmag[2] + grav;
			else if (fmag[2] >= grav)
				fmag[2] = fmag[2] - grav;
			else begin
				fneg[2] = 1'b1;
				fmag[2] = grav - fmag[2];
			end
			p.accel_x = 32'(clamp_signed(fneg[0], (fmag[0] << 16) / 128'(r.mass), 32));
			p.accel_y = 32'(clamp_signed(fneg[1], (fmag[1] << 16) / 128'(r.mass), 32));
			p.accel_z = 32'(clamp_signed(fneg[2], (fmag[2] << 16) / 128'(r.mass), 32));
			p.force_x = 48'(clamp_signed(fneg[0], fmag[0], 48));
			p.force_y = 48'(clamp_signed(fneg[1], fmag[1], 48));
			p.force_z = 48'(clamp_signed(fneg[2], fmag[2], 48));
			return p;
		endfunction

		function void note_request(pmdg_pkg::req_t r);
			pending.push_back(predict(r));
		endfunction

		function void compare_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
			if (exp_v !== act_v) begin
				errors++;
				$display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
			end
		endfunction

		function void check_result(pmdg_pkg::rsp_t r);
			pmdg_pkg::rsp_t e;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: unexpected result, actual %h", $time, r);
				return;
			end
			e = pending.pop_front();
			checked++;
			if (e.mass_fault) faults++;
			compare_field("accel_x", 64'(e.accel_x), 64'(r.accel_x));
			compare_field("accel_y", 64'(e.accel_y), 64'(r.accel_y));
			compare_field("accel_z", 64'(e.accel_z), 64'(r.accel_z));
			compare_field("force_x", 64'(e.force_x), 64'(r.force_x));
			compare_field("force_y", 64'(e.force_y), 64'(r.force_y));
			compare_field("force_z", 64'(e.force_z), 64'(r.force_z));
			compare_field("dyn_pressure", 64'(e.dyn_pressure), 64'(r.dyn_pressure));
			compare_field("mass_fault", 64'(e.mass_fault), 64'(r.mass_fault));
		endfunction
	endclass

	logic            clk;
	logic            arst_n;
	logic            start;
	logic            busy;
	pmdg_pkg::req_t  req;
	logic            cfg_valid;
	logic            cfg_ready;
	logic [1:0]      cfg_index;
	logic [31:0]     cfg_data;
	pmdg_pkg::rsp_t  result;
	logic            done;

	drag_scoreboard sb;
	int             cycles;
	int             sent;
	int             quiet_from;
	int             quiet_to;

	point_mass_drag_gravity_derivative i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result),
		.done      (done)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Result capture and run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (arst_n && done)
			sb.check_result(result);
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
			$display("point_mass_drag_gravity_derivative regression: fail");
			$finish;
		end
	end

	// Write one register through the configuration channel.
	task automatic write_reg(logic [1:0] index, logic [31:0] data);
		@(negedge clk);
		while ($urandom_range(99) < 6) @(negedge clk);
		cfg_valid = 1'b1;
		cfg_index = index;
		cfg_data  = data;
		do @(posedge clk); while (!cfg_ready);
		if (index == pmdg_pkg::REG_GRAVITY) sb.gravity = data;
		else if (index == pmdg_pkg::REG_DENSITY) sb.density = data;
		@(negedge clk);
		cfg_valid = 1'b0;
	endtask

	// Present one request and hold it until accepted.
	task automatic send_request(pmdg_pkg::req_t r);
		@(negedge clk);
		if (!(sent >= quiet_from && sent < quiet_to)) begin
			while ($urandom_range(99) < 6) begin
				start = 1'b0;
				@(negedge clk);
			end
		end
		start = 1'b1;
		req   = r;
		do @(posedge clk); while (busy);
		sb.note_request(r);
		sent++;
	endtask

	task automatic release_start();
		@(negedge clk);
		start = 1'b0;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (pmdg_pkg::LATENCY + 10) @(posedge clk);
	endtask

	function automatic logic [31:0] rand_velocity();
		case ($urandom_range(5))
			0: return $urandom();
			1: return 0;
			2: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7FFF_FFFF;
			default: return ($urandom_range(1)) ? -$urandom_range(400 << 16)
			                                     : $urandom_range(400 << 16);
		endcase
	endfunction

	function automatic pmdg_pkg::req_t rand_request();
		pmdg_pkg::req_t r;
		r.vel_x = rand_velocity();
		r.vel_y = rand_velocity();
		r.vel_z = rand_velocity();
		case ($urandom_range(3))
			0: r.air_density = $urandom();
			1: r.air_density = 0;
			default: r.air_density = $urandom_range(32'h0200_0000);
		endcase
		case ($urandom_range(9))
			0: r.mass = 0;
			1, 2: r.mass = $urandom();
			3: r.mass = $urandom_range(255);
			default: r.mass = $urandom_range(1 << 16, 5000 << 16);
		endcase
		r.drag_coef = ($urandom_range(2) == 0) ? 16'($urandom()) : 16'($urandom_range(1 << 13));
		case ($urandom_range(4))
			0: r.ref_area = 0;
			1: r.ref_area = $urandom();
			default: r.ref_area = $urandom_range(20 << 16);
		endcase
		return r;
	endfunction

	function automatic pmdg_pkg::req_t make_request(logic [31:0] vx, logic [31:0] vy,
			logic [31:0] vz, logic [31:0] rho, logic [31:0] m, logic [15:0] cx,
			logic [31:0] area);
		pmdg_pkg::req_t r;
		r.vel_x = vx;
		r.vel_y = vy;
		r.vel_z = vz;
		r.air_density = rho;
		r.mass = m;
		r.drag_coef = cx;
		r.ref_area = area;
		return r;
	endfunction

	// Directed corner cases, run under reset register values and again with no gravity.
	task automatic directed_requests();
		send_request(make_request(0, 0, 0, 0, 32'h10000, 16'h1000, 32'h10000));
		send_request(make_request(32'h100000, 0, 0, 32'h1000000, 0, 16'h1000, 32'h10000));
		send_request(make_request(32'h100000, 32'h200000, 32'h300000, 0, 32'h10000, 16'h1000, 0));
		send_request(make_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, '1, '1, '1, '1));
		send_request(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '1, 1, '1, '1));
		send_request(make_request(32'h7FFF_FFFF, 32'h8000_0000, 0, '1, '1, '1, '1));
		send_request(make_request(0, 0, 32'h0A00000, 32'h1000000, 32'h10000, 16'h2000, 32'h10000));
		send_request(make_request(0, 0, -32'sh0A00000, 32'h1000000, 32'h10000, 16'h2000, 32'h10000));
		send_request(make_request(32'h1, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h1, 16'h1, 32'h1));
		send_request(make_request(0, 0, 0, 0, '1, 0, 0));
		send_request(make_request(0, 0, 0, 0, 1, 0, 0));
		send_request(make_request(32'h12345678, -32'sh1234567, 32'h7654321, 0, 32'h8000,
			16'hFFFF, 32'hFFFF_FFFF));
		send_request(make_request(32'h3200000, 0, 32'h1000000, 32'h1000000, 32'h5_0000,
			16'h0800, 32'h2_0000));
		send_request(make_request(32'hAAAA_AAAA, 32'h5555_5555, 32'hCCCC_CCCC, 32'h5555_5555,
			32'hAAAA_AAAA, 16'h5555, 32'hAAAA_AAAA));
		send_request(make_request(0, 0, 0, 0, 0, 0, 0));
		release_start();
	endtask

	task automatic random_requests(int count);
		for (int i = 0; i < count; i++)
			send_request(rand_request());
		release_start();
	endtask

	initial begin
		sb        = new();
		cycles    = 0;
		sent      = 0;
		quiet_from = 200;
		quiet_to   = 320;
		arst_n    = 1'b0;
		start     = 1'b0;
		req       = '0;
		cfg_valid = 1'b0;
		cfg_index = pmdg_pkg::REG_GRAVITY;
		cfg_data  = '0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Reset register values first.
		directed_requests();
		random_requests(110);
		drain();

		// No gravity, densest default air.
		write_reg(pmdg_pkg::REG_GRAVITY, 32'd0);
		write_reg(pmdg_pkg::REG_DENSITY, 32'hFFFF_FFFF);
		directed_requests();
		random_requests(100);
		drain();

		// Largest gravity, thinnest default air.
		write_reg(pmdg_pkg::REG_GRAVITY, 32'hFFFF_FFFF);
		write_reg(pmdg_pkg::REG_DENSITY, 32'd1);
		random_requests(110);
		drain();

		// Default density of zero removes drag for zero-density requests.
		write_reg(pmdg_pkg::REG_DENSITY, 32'd0);
		write_reg(pmdg_pkg::REG_GRAVITY, 32'd642690);
		random_requests(110);
		drain();

		// Random register values.
		write_reg(pmdg_pkg::REG_GRAVITY, $urandom());
		write_reg(pmdg_pkg::REG_DENSITY, $urandom());
		random_requests(110);
		drain();

		$display("Covered %0d requests over five register settings, %0d results checked,",
			sent, sb.checked);
		$display("%0d of them with zero mass; %0d mismatches.", sb.faults, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("point_mass_drag_gravity_derivative regression: pass");
		else
			$display("point_mass_drag_gravity_derivative regression: fail");
		$finish;
	end

endmodule
